FILE: hw/rtl/deu_pkg.sv
// Shared types and constants for the digitizer event unpacker.
package deu_pkg;

   localparam int WORD_W      = 32;
   localparam int KIND_W      = 4;
   localparam int SAMPLE_W    = 12;
   localparam int SET_W       = 10;
   localparam int SAMPLE_SETS = 1024;

   localparam logic [SET_W-1:0] SET_LAST = SET_W'(SAMPLE_SETS - 1);

   localparam logic [KIND_W-1:0] KIND_SAMPLE = 4'd8;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 4'd9;
   localparam logic [KIND_W-1:0] KIND_GROUP  = 4'd5;

   localparam logic [2:0] HDR_SIZE    = 3'd4;
   localparam logic [2:0] HDR_GROUP   = 3'd5;
   localparam logic [2:0] HDR_COUNTER = 3'd6;
   localparam logic [2:0] HDR_LAST    = 3'd7;

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   localparam logic [WORD_W-1:0] SIZE_MASK    = 32'h0FFF_FFFF;
   localparam logic [WORD_W-1:0] COUNTER_MASK = 32'h003F_FFFF;

   typedef enum logic [1:0] {
      ST_HEADER,
      ST_GROUP_CHECK,
      ST_DATA,
      ST_TRAILER
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [WORD_W-1:0]   header_value;
      logic [SET_W-1:0]    sample_index;
      logic [SAMPLE_W-1:0] sample_zero;
      logic [SAMPLE_W-1:0] sample_one;
      logic [SAMPLE_W-1:0] sample_two;
      logic [SAMPLE_W-1:0] sample_three;
      logic [SAMPLE_W-1:0] sample_four;
      logic [SAMPLE_W-1:0] sample_five;
      logic [SAMPLE_W-1:0] sample_six;
      logic [SAMPLE_W-1:0] sample_seven;
      logic                event_end;
   } result_type;

endpackage

FILE: hw/rtl/digitizer_event_unpacker_unit.sv
// Top level of the digitizer event unpacker.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid, req_stall | req_stream_word
//   rsp_    | out       | rsp_valid, rsp_stall | kind, header_value, sample fields, event_end
//
// One word is accepted every cycle unless req_stall is high; its result is then registered.
// A word that yields no result, such as the first two words of a triple, is dropped silently.
// Reset returns the position counter to the start of an event and empties both registers.
// A stalled result holds, and the input register then takes at most one more word.
module digitizer_event_unpacker_unit
   import deu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [WORD_W-1:0]   req_stream_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [WORD_W-1:0]   rsp_header_value,
   output logic [SET_W-1:0]    rsp_sample_index,
   output logic [SAMPLE_W-1:0] rsp_sample_zero,
   output logic [SAMPLE_W-1:0] rsp_sample_one,
   output logic [SAMPLE_W-1:0] rsp_sample_two,
   output logic [SAMPLE_W-1:0] rsp_sample_three,
   output logic [SAMPLE_W-1:0] rsp_sample_four,
   output logic [SAMPLE_W-1:0] rsp_sample_five,
   output logic [SAMPLE_W-1:0] rsp_sample_six,
   output logic [SAMPLE_W-1:0] rsp_sample_seven,
   output logic                rsp_event_end
);

   logic              out_ready;
   logic              in_valid;
   logic [WORD_W-1:0] in_word;
   logic              res_valid;
   result_type        res;
   result_type        rsp;

   deu_input_reg u_input_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_word (req_stream_word),
      .out_ready       (out_ready),
      .in_valid        (in_valid),
      .in_word         (in_word)
   );

   deu_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_word   (in_word),
      .out_ready (out_ready),
      .res_valid (res_valid),
      .res       (res)
   );

   deu_result_reg u_result_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .res_valid (res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_kind         = rsp.kind;
   assign rsp_header_value = rsp.header_value;
   assign rsp_sample_index = rsp.sample_index;
   assign rsp_sample_zero  = rsp.sample_zero;
   assign rsp_sample_one   = rsp.sample_one;
   assign rsp_sample_two   = rsp.sample_two;
   assign rsp_sample_three = rsp.sample_three;
   assign rsp_sample_four  = rsp.sample_four;
   assign rsp_sample_five  = rsp.sample_five;
   assign rsp_sample_six   = rsp.sample_six;
   assign rsp_sample_seven = rsp.sample_seven;
   assign rsp_event_end    = rsp.event_end;

endmodule

FILE: hw/rtl/deu_input_reg.sv
// Input register that holds one stream word and raises stall while it cannot move on.
module deu_input_reg
   import deu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [WORD_W-1:0] req_stream_word,
   input  logic              out_ready,
   output logic              in_valid,
   output logic [WORD_W-1:0] in_word
);

   logic              valid_ff;
   logic              valid_in;
   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   assign req_stall = valid_ff && !out_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         if (req_valid) begin
            word_in = req_stream_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign in_valid = valid_ff;
   assign in_word  = word_ff;

endmodule

FILE: hw/rtl/deu_decoder.sv
// Event position sequencer and field decoder for one stream word.
module deu_decoder
   import deu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [WORD_W-1:0] in_word,
   input  logic              out_ready,
   output logic              res_valid,
   output result_type        res
);

   state_type         state_ff, state_in;
   logic [2:0]        hdr_pos_ff, hdr_pos_in;
   logic [1:0]        phase_ff, phase_in;
   logic [SET_W-1:0]  set_ff, set_in;
   logic              trailer_ff, trailer_in;
   logic              no_groups_ff, no_groups_in;
   logic [WORD_W-1:0] first_ff, first_in;
   logic [WORD_W-1:0] second_ff, second_in;
   logic              fire;
   logic [3:0]        mask;
   logic [2:0]        count;

   assign fire  = in_valid && out_ready;
   assign mask  = in_word[3:0];
   assign count = {2'b00, mask[0]} + {2'b00, mask[1]} + {2'b00, mask[2]} + {2'b00, mask[3]};

   always_comb begin
      state_in     = state_ff;
      hdr_pos_in   = hdr_pos_ff;
      phase_in     = phase_ff;
      set_in       = set_ff;
      trailer_in   = trailer_ff;
      no_groups_in = no_groups_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      if (fire) begin
         case (state_ff)
            ST_HEADER: begin
               if (hdr_pos_ff == HDR_GROUP) begin
                  no_groups_in = (mask == 4'd0);
               end
               if (hdr_pos_ff == HDR_LAST) begin
                  state_in   = ST_GROUP_CHECK;
                  hdr_pos_in = 3'd0;
               end else begin
                  hdr_pos_in = hdr_pos_ff + 3'd1;
               end
            end
            ST_GROUP_CHECK: begin
               phase_in = PH_FIRST;
               set_in   = '0;
               if (no_groups_ff) begin
                  state_in = ST_HEADER;
               end else begin
                  state_in = ST_DATA;
               end
            end
            ST_DATA: begin
               case (phase_ff)
                  PH_FIRST: begin
                     first_in = in_word;
                     phase_in = PH_SECOND;
                  end
                  PH_SECOND: begin
                     second_in = in_word;
                     phase_in  = PH_THIRD;
                  end
                  default: begin
                     phase_in = PH_FIRST;
                     if (set_ff == SET_LAST) begin
                        state_in   = ST_TRAILER;
                        trailer_in = 1'b0;
                     end else begin
                        set_in = set_ff + 1'b1;
                     end
                  end
               endcase
            end
            ST_TRAILER: begin
               if (trailer_ff) begin
                  state_in   = ST_HEADER;
                  hdr_pos_in = 3'd0;
               end else begin
                  trailer_in = 1'b1;
               end
            end
            default: begin
               state_in   = ST_HEADER;
               hdr_pos_in = 3'd0;
            end
         endcase
      end
   end

   always_comb begin
      res       = '0;
      res_valid = 1'b0;
      case (state_ff)
         ST_HEADER: begin
            res_valid = 1'b1;
            res.kind  = {1'b0, hdr_pos_ff};
            case (hdr_pos_ff)
               HDR_SIZE:    res.header_value = in_word & SIZE_MASK;
               HDR_GROUP:   res.header_value = {24'd0, mask, 1'b0, count};
               HDR_COUNTER: res.header_value = in_word & COUNTER_MASK;
               default:     res.header_value = in_word;
            endcase
         end
         ST_GROUP_CHECK: begin
            if (no_groups_ff) begin
               res_valid     = 1'b1;
               res.kind      = KIND_ERROR;
               res.event_end = 1'b1;
            end
         end
         ST_DATA: begin
            if (phase_ff == PH_THIRD) begin
               res_valid        = 1'b1;
               res.kind         = KIND_SAMPLE;
               res.sample_index = set_ff;
               res.sample_zero  = first_ff[11:0];
               res.sample_one   = first_ff[23:12];
               res.sample_two   = {second_ff[3:0], first_ff[31:24]};
               res.sample_three = second_ff[15:4];
               res.sample_four  = second_ff[27:16];
               res.sample_five  = {in_word[7:0], second_ff[31:28]};
               res.sample_six   = in_word[19:8];
               res.sample_seven = in_word[31:20];
               res.event_end    = (set_ff == SET_LAST);
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HEADER;
         hdr_pos_ff   <= 3'd0;
         phase_ff     <= PH_FIRST;
         set_ff       <= '0;
         trailer_ff   <= 1'b0;
         no_groups_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hdr_pos_ff   <= hdr_pos_in;
         phase_ff     <= phase_in;
         set_ff       <= set_in;
         trailer_ff   <= trailer_in;
         no_groups_ff <= no_groups_in;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
   end

endmodule

FILE: hw/rtl/deu_result_reg.sv
// Result register that holds one decoded word until the receiver takes it.
module deu_result_reg
   import deu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic       res_valid,
   input  result_type res,
   input  logic       rsp_stall,
   output logic       out_ready,
   output logic       rsp_valid,
   output result_type rsp
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (out_ready) begin
         valid_in = in_valid && res_valid;
         data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

FILE: hw/rtl/deu_checker.sv
// Port-level checker for the digitizer event unpacker and its bind statement.
module deu_checker
   import deu_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [KIND_W-1:0]   rsp_kind,
   input logic [WORD_W-1:0]   rsp_header_value,
   input logic                rsp_event_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_header_value) && $stable(rsp_event_end))
      else $error("A stalled result word changed or was withdrawn.");

   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERROR |-> rsp_event_end && rsp_header_value == '0)
      else $error("The no-groups error word did not close the event.");

   a_header_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SAMPLE && rsp_kind != KIND_ERROR |-> !rsp_event_end)
      else $error("A header word was marked as the end of an event.");

   a_group_format: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_GROUP |->
         rsp_header_value[31:8] == '0 && rsp_header_value[3] == 1'b0
         && rsp_header_value[2:0] == 3'($countones(rsp_header_value[7:4])))
      else $error("The group word count does not match its mask.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("A result word was shown straight after reset.");

endmodule

bind digitizer_event_unpacker_unit deu_checker u_deu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_header_value (rsp_header_value),
   .rsp_event_end    (rsp_event_end)
);

FILE: tb/deu_stream_checker.sv
// Checker that predicts the unpacker's results from the accepted stream words and compares them.
module deu_stream_checker
   import deu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [WORD_W-1:0]   req_stream_word,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [KIND_W-1:0]   rsp_kind,
   input  logic [WORD_W-1:0]   rsp_header_value,
   input  logic [SET_W-1:0]    rsp_sample_index,
   input  logic [SAMPLE_W-1:0] rsp_sample_zero,
   input  logic [SAMPLE_W-1:0] rsp_sample_one,
   input  logic [SAMPLE_W-1:0] rsp_sample_two,
   input  logic [SAMPLE_W-1:0] rsp_sample_three,
   input  logic [SAMPLE_W-1:0] rsp_sample_four,
   input  logic [SAMPLE_W-1:0] rsp_sample_five,
   input  logic [SAMPLE_W-1:0] rsp_sample_six,
   input  logic [SAMPLE_W-1:0] rsp_sample_seven,
   input  logic                rsp_event_end,
   output int                  error_count,
   output int                  pending_count,
   output int                  results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [11:0] GROUP_CHECK_POS = 12'd8;
   localparam logic [11:0] FIRST_DATA_POS  = 12'd9;
   localparam logic [11:0] LAST_DATA_POS   = 12'(9 + 3 * SAMPLE_SETS - 1);
   localparam logic [11:0] TRAILER_END_POS = LAST_DATA_POS + 12'd2;
   localparam int          PRINT_LIMIT     = 40;

   logic [11:0]       word_pos;
   logic [WORD_W-1:0] held_first;
   logic [WORD_W-1:0] held_second;
   logic              no_groups;
   result_type        expected_results[$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("ERROR: %s on result %0d: got 0x%0h, expected 0x%0h",
                  what, results_checked, got, want);
   endtask

   task automatic unpack_word(input logic [WORD_W-1:0] w, output bit produced,
                              output result_type r);
      logic [11:0] rel;
      logic [3:0]  mask;
      logic [2:0]  active;
      produced = 1'b0;
      r = '0;
      if (word_pos <= 12'(HDR_LAST)) begin
         produced = 1'b1;
         r.kind = KIND_W'(word_pos);
         r.header_value = w;
         if (word_pos == 12'(HDR_SIZE)) begin
            r.header_value = w & SIZE_MASK;
         end else if (word_pos == 12'(HDR_GROUP)) begin
            mask = w[3:0];
            active = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
            no_groups = (mask == 4'd0);
            r.header_value = (32'(mask) << 4) | 32'(active);
         end else if (word_pos == 12'(HDR_COUNTER)) begin
            r.header_value = w & COUNTER_MASK;
         end
         word_pos = word_pos + 12'd1;
      end else if (word_pos == GROUP_CHECK_POS) begin
         if (no_groups) begin
            produced = 1'b1;
            r.kind = KIND_ERROR;
            r.event_end = 1'b1;
            word_pos = 12'd0;
         end else begin
            word_pos = word_pos + 12'd1;
         end
      end else if (word_pos <= LAST_DATA_POS) begin
         rel = word_pos - FIRST_DATA_POS;
         case (2'(rel % 12'd3))
            PH_FIRST: begin
               held_first = w;
            end
            PH_SECOND: begin
               held_second = w;
            end
            default: begin
               produced = 1'b1;
               r.kind = KIND_SAMPLE;
               r.sample_index = SET_W'(rel / 12'd3);
               r.sample_zero  = held_first[11:0];
               r.sample_one   = held_first[23:12];
               r.sample_two   = {held_second[3:0], held_first[31:24]};
               r.sample_three = held_second[15:4];
               r.sample_four  = held_second[27:16];
               r.sample_five  = {w[7:0], held_second[31:28]};
               r.sample_six   = w[19:8];
               r.sample_seven = w[31:20];
               r.event_end    = (word_pos == LAST_DATA_POS);
            end
         endcase
         word_pos = word_pos + 12'd1;
      end else if (word_pos >= TRAILER_END_POS) begin
         word_pos = 12'd0;
      end else begin
         word_pos = word_pos + 12'd1;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      bit         produced;
      if (reset) begin
         word_pos = 12'd0;
         held_first = '0;
         held_second = '0;
         no_groups = 1'b0;
         expected_results.delete();
         error_count = 0;
         results_checked = 0;
      end else begin
         if (req_valid && !req_stall) begin
            unpack_word(req_stream_word, produced, want);
            if (produced)
               expected_results.insert(expected_results.size(), want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_kind), 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind mismatch", 32'(rsp_kind), 32'(want.kind));
               if (rsp_header_value !== want.header_value)
                  report_mismatch("header_value mismatch", rsp_header_value,
                                  want.header_value);
               if (rsp_sample_index !== want.sample_index)
                  report_mismatch("sample_index mismatch", 32'(rsp_sample_index),
                                  32'(want.sample_index));
               if (rsp_sample_zero !== want.sample_zero)
                  report_mismatch("sample_zero mismatch", 32'(rsp_sample_zero),
                                  32'(want.sample_zero));
               if (rsp_sample_one !== want.sample_one)
                  report_mismatch("sample_one mismatch", 32'(rsp_sample_one),
                                  32'(want.sample_one));
               if (rsp_sample_two !== want.sample_two)
                  report_mismatch("sample_two mismatch", 32'(rsp_sample_two),
                                  32'(want.sample_two));
               if (rsp_sample_three !== want.sample_three)
                  report_mismatch("sample_three mismatch", 32'(rsp_sample_three),
                                  32'(want.sample_three));
               if (rsp_sample_four !== want.sample_four)
                  report_mismatch("sample_four mismatch", 32'(rsp_sample_four),
                                  32'(want.sample_four));
               if (rsp_sample_five !== want.sample_five)
                  report_mismatch("sample_five mismatch", 32'(rsp_sample_five),
                                  32'(want.sample_five));
               if (rsp_sample_six !== want.sample_six)
                  report_mismatch("sample_six mismatch", 32'(rsp_sample_six),
                                  32'(want.sample_six));
               if (rsp_sample_seven !== want.sample_seven)
                  report_mismatch("sample_seven mismatch", 32'(rsp_sample_seven),
                                  32'(want.sample_seven));
               if (rsp_event_end !== want.event_end)
                  report_mismatch("event_end mismatch", 32'(rsp_event_end),
                                  32'(want.event_end));
               results_checked++;
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

FILE: tb/digitizer_event_unpacker_unit_tb.sv
// Top of the unpacker testbench: clock, reset, event stream stimulus, receiver stalls and verdict.
module digitizer_event_unpacker_unit_tb
   import deu_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ERROR_PHASE_WORDS = 270;
   localparam int HOLD_OFF_CYCLES   = 400;
   localparam int DRAIN_CYCLES      = 20;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [WORD_W-1:0]   req_stream_word;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [KIND_W-1:0]   rsp_kind;
   logic [WORD_W-1:0]   rsp_header_value;
   logic [SET_W-1:0]    rsp_sample_index;
   logic [SAMPLE_W-1:0] rsp_sample_zero;
   logic [SAMPLE_W-1:0] rsp_sample_one;
   logic [SAMPLE_W-1:0] rsp_sample_two;
   logic [SAMPLE_W-1:0] rsp_sample_three;
   logic [SAMPLE_W-1:0] rsp_sample_four;
   logic [SAMPLE_W-1:0] rsp_sample_five;
   logic [SAMPLE_W-1:0] rsp_sample_six;
   logic [SAMPLE_W-1:0] rsp_sample_seven;
   logic                rsp_event_end;

   int error_count;
   int pending_count;
   int results_checked;

   int words_sent;
   int events_sent;
   int full_events;
   int burst_left;
   bit valid_high;

   digitizer_event_unpacker_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stream_word  (req_stream_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_header_value (rsp_header_value),
      .rsp_sample_index (rsp_sample_index),
      .rsp_sample_zero  (rsp_sample_zero),
      .rsp_sample_one   (rsp_sample_one),
      .rsp_sample_two   (rsp_sample_two),
      .rsp_sample_three (rsp_sample_three),
      .rsp_sample_four  (rsp_sample_four),
      .rsp_sample_five  (rsp_sample_five),
      .rsp_sample_six   (rsp_sample_six),
      .rsp_sample_seven (rsp_sample_seven),
      .rsp_event_end    (rsp_event_end)
   );

   deu_stream_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stream_word  (req_stream_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_header_value (rsp_header_value),
      .rsp_sample_index (rsp_sample_index),
      .rsp_sample_zero  (rsp_sample_zero),
      .rsp_sample_one   (rsp_sample_one),
      .rsp_sample_two   (rsp_sample_two),
      .rsp_sample_three (rsp_sample_three),
      .rsp_sample_four  (rsp_sample_four),
      .rsp_sample_five  (rsp_sample_five),
      .rsp_sample_six   (rsp_sample_six),
      .rsp_sample_seven (rsp_sample_seven),
      .rsp_event_end    (rsp_event_end),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .results_checked  (results_checked)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_word(input logic [WORD_W-1:0] w);
      req_valid <= 1'b1;
      req_stream_word <= w;
      valid_high = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         valid_high = 1'b0;
         repeat ($urandom_range(1, 6))
            @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 40);
      end
   endtask

   task automatic wait_for_drain();
      if (valid_high) begin
         req_valid <= 1'b0;
         valid_high = 1'b0;
      end
      do
         @(negedge clock);
      while (pending_count != 0);
      @(posedge clock);
   endtask

   task automatic send_event(input logic [3:0] mask);
      logic [WORD_W-1:0] hdr;
      for (int i = 0; i <= int'(HDR_LAST); i++) begin
         hdr = pick_word();
         if (i == int'(HDR_GROUP))
            hdr[3:0] = mask;
         send_word(hdr);
      end
      send_word(pick_word());
      if (mask != 4'd0) begin
         for (int set = 0; set < SAMPLE_SETS; set++) begin
            for (int k = 0; k < 3; k++) begin
               if (set == 0 || set == SAMPLE_SETS - 1)
                  send_word('1);
               else if (set == 1)
                  send_word('0);
               else
                  send_word(pick_word());
            end
         end
         send_word(pick_word());
         send_word(pick_word());
         full_events++;
      end
      events_sent++;
   endtask

   // Receiver stall pattern, with one long hold-off early in the run.
   initial begin : receiver
      int segment;
      int mode;
      rsp_stall <= 1'b0;
      segment = 0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         segment++;
         if (segment == 4) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES)
               @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(16, 160)) begin
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                  2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= ~rsp_stall;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      logic [WORD_W-1:0] directed_words [18];
      logic [3:0]        mask;
      directed_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0000_0000,
                         32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                         32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                         32'h0000_0000};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_stream_word <= '0;
      words_sent = 0;
      events_sent = 0;
      full_events = 0;
      burst_left = 0;
      valid_high = 1'b0;
      repeat (8)
         @(posedge clock);
      reset <= 1'b0;

      // Two events without active groups, with the header fields at their extremes.
      foreach (directed_words[i])
         send_word(directed_words[i]);
      events_sent += 2;
      wait_for_drain();

      // Short error events with random headers, then one event carrying every sample set.
      while (full_events == 0) begin
         if (words_sent < ERROR_PHASE_WORDS)
            mask = 4'd0;
         else
            mask = 4'($urandom_range(1, 15));
         send_event(mask);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES)
         @(posedge clock);

      $display("Summary: %0d stream words in %0d events, %0d with sample data;",
               words_sent, events_sent, full_events);
      $display("Summary: %0d results checked under random bursts, stalls and a long hold-off.",
               results_checked);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Timeout with %0d results still outstanding.", pending_count);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/deu_pkg.sv
hw/rtl/deu_input_reg.sv
hw/rtl/deu_decoder.sv
hw/rtl/deu_result_reg.sv
hw/rtl/digitizer_event_unpacker_unit.sv
hw/rtl/deu_checker.sv
tb/deu_stream_checker.sv
tb/digitizer_event_unpacker_unit_tb.sv
